>>> rtl/tel_pkg.sv
// Package for the template expression lexer: item types, token codes and character constants.
package tel_pkg;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_source;
	} src_item_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [1:0]  error_kind;
		logic [15:0] token_offset;
		logic [15:0] token_length;
		logic [15:0] line_number;
		logic [15:0] column_number;
		logic        last_of_run;
	} tok_item_t;

	localparam logic [3:0] K_END       = 4'd0;
	localparam logic [3:0] K_TEXT      = 4'd1;
	localparam logic [3:0] K_SEQ_START = 4'd2;
	localparam logic [3:0] K_SEQ_END   = 4'd3;
	localparam logic [3:0] K_COMMA     = 4'd4;
	localparam logic [3:0] K_LPAREN    = 4'd5;
	localparam logic [3:0] K_RPAREN    = 4'd6;
	localparam logic [3:0] K_STRING    = 4'd7;
	localparam logic [3:0] K_IDENT     = 4'd8;
	localparam logic [3:0] K_OR        = 4'd9;
	localparam logic [3:0] K_ERROR     = 4'd10;

	localparam logic [1:0] E_NONE       = 2'd0;
	localparam logic [1:0] E_UNEXPECTED = 2'd1;
	localparam logic [1:0] E_UNTERM     = 2'd2;

	localparam logic [1:0] OPEN_NONE   = 2'd0;
	localparam logic [1:0] OPEN_RUN    = 2'd1;
	localparam logic [1:0] OPEN_STRING = 2'd2;
	localparam logic [1:0] OPEN_IDENT  = 2'd3;

	localparam logic [1:0] KW_NONE = 2'd0;
	localparam logic [1:0] KW_O    = 2'd1;
	localparam logic [1:0] KW_OR   = 2'd2;

	localparam logic [7:0] CH_PERCENT   = 8'h25;
	localparam logic [7:0] CH_LBRACE    = 8'h7b;
	localparam logic [7:0] CH_RBRACE    = 8'h7d;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_LOWER_O   = 8'h6f;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_NEWLINE   = 8'h0a;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_COMMA     = 8'h2c;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_QUOTE     = 8'h27;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_Z   = 8'h7a;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_Z   = 8'h5a;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;

	localparam int QUEUE_DEPTH = 3;

endpackage

>>> rtl/template_expression_lexer_top.sv
// Top level of the template expression lexer: input register, lexing step, token queue.
// An accepted item waits in the input register and is lexed once the token queue has room;
// its one or two tokens enter the queue together and are offered in order.
// Throughput: one item per cycle while each item yields at most one token and tok_ready stays
// high; the single output port sets the rate, so an item yielding two tokens stalls the input.
// Reset: arst_n clears to text mode, offset 0, line 1, column 0, with the token queue empty.
module template_expression_lexer_top #(
	parameter int POSITION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  tel_pkg::src_item_t  src_item,
	output logic                tok_valid,
	input  logic                tok_ready,
	output tel_pkg::tok_item_t  tok_item
);

	localparam int P = POSITION_BITS;

	function automatic logic [15:0] to16(input logic [P-1:0] v);
		logic [P+15:0] e;
		e = {16'b0, v};
		return e[15:0];
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= tel_pkg::CH_LOWER_A && c <= tel_pkg::CH_LOWER_Z) ||
		       (c >= tel_pkg::CH_UPPER_A && c <= tel_pkg::CH_UPPER_Z) ||
		       (c == tel_pkg::CH_UNDERSCORE);
	endfunction

	function automatic tel_pkg::tok_item_t mk(input logic [3:0] kind, input logic [1:0] err,
			input logic [P-1:0] off, input logic [P-1:0] len, input logic [15:0] line,
			input logic [15:0] col);
		tel_pkg::tok_item_t t;
		t.token_kind    = kind;
		t.error_kind    = err;
		t.token_offset  = to16(off);
		t.token_length  = to16(len);
		t.line_number   = line;
		t.column_number = col;
		t.last_of_run   = 1'b0;
		return t;
	endfunction

	logic               s1_valid_s1;
	tel_pkg::src_item_t s1_item_s1;

	logic         in_expr_q;
	logic [1:0]   open_kind_q;
	logic [P-1:0] open_off_q;
	logic [P-1:0] pos_q;
	logic [15:0]  line_q;
	logic [15:0]  col_q;
	logic         held_pct_q;
	logic         prior_bs_q;
	logic [1:0]   kw_q;

	tel_pkg::tok_item_t q_q [tel_pkg::QUEUE_DEPTH];
	logic [1:0]         cnt_q;

	logic process;
	logic pop;

	assign tok_valid = (cnt_q != 2'd0);
	assign tok_item  = q_q[0];
	assign pop       = tok_valid && tok_ready;
	assign process   = s1_valid_s1 && (cnt_q <= 2'd1);
	assign src_ready = !s1_valid_s1 || process;

	logic         nx_in_expr;
	logic [1:0]   nx_open_kind;
	logic [P-1:0] nx_open_off;
	logic [P-1:0] nx_pos;
	logic [15:0]  nx_line;
	logic [15:0]  nx_col;
	logic         nx_held_pct;
	logic         nx_prior_bs;
	logic [1:0]   nx_kw;
	tel_pkg::tok_item_t res [2];
	logic [1:0]   nres;

	always_comb begin
		logic [7:0]   b;
		logic [15:0]  col1;
		logic         done;
		logic         fresh;
		b            = s1_item_s1.source_byte;
		col1         = col_q + 16'd1;
		done         = 1'b0;
		fresh        = 1'b0;
		nx_in_expr   = in_expr_q;
		nx_open_kind = open_kind_q;
		nx_open_off  = open_off_q;
		nx_pos       = pos_q;
		nx_line      = line_q;
		nx_col       = col_q;
		nx_held_pct  = held_pct_q;
		nx_prior_bs  = prior_bs_q;
		nx_kw        = kw_q;
		res[0]       = mk(tel_pkg::K_END, tel_pkg::E_NONE, pos_q, '0, line_q, col_q);
		res[1]       = res[0];
		nres         = 2'd0;
		if (s1_item_s1.end_of_source) begin
			if (!in_expr_q) begin
				if (held_pct_q || open_kind_q == tel_pkg::OPEN_RUN) begin
					res[0] = mk(tel_pkg::K_TEXT, tel_pkg::E_NONE, open_off_q,
						pos_q - open_off_q, line_q, col_q);
					nres = 2'd1;
				end
			end else if (open_kind_q == tel_pkg::OPEN_IDENT) begin
				res[0] = mk((kw_q == tel_pkg::KW_OR) ? tel_pkg::K_OR : tel_pkg::K_IDENT,
					tel_pkg::E_NONE, open_off_q, pos_q - open_off_q, line_q, col_q);
				nres = 2'd1;
			end else if (open_kind_q == tel_pkg::OPEN_STRING) begin
				res[0] = mk(tel_pkg::K_ERROR, tel_pkg::E_UNTERM, open_off_q, '0, line_q, col_q);
				nres = 2'd1;
			end
			res[nres[0]] = mk(tel_pkg::K_END, tel_pkg::E_NONE, pos_q, '0, line_q, col_q);
			nres = nres + 2'd1;
			nx_in_expr   = 1'b0;
			nx_open_kind = tel_pkg::OPEN_NONE;
			nx_open_off  = '0;
			nx_pos       = '0;
			nx_line      = 16'd1;
			nx_col       = 16'd0;
			nx_held_pct  = 1'b0;
			nx_prior_bs  = 1'b0;
			nx_kw        = tel_pkg::KW_NONE;
		end else begin
			nx_pos = pos_q + 1'b1;
			nx_col = col1;
			if (!in_expr_q) begin
				if (held_pct_q) begin
					nx_held_pct = 1'b0;
					if (b == tel_pkg::CH_LBRACE) begin
						if (open_kind_q == tel_pkg::OPEN_RUN) begin
							res[0] = mk(tel_pkg::K_TEXT, tel_pkg::E_NONE, open_off_q,
								pos_q - 1'b1 - open_off_q, line_q, col_q - 16'd1);
							nres = 2'd1;
						end
						res[nres[0]] = mk(tel_pkg::K_SEQ_START, tel_pkg::E_NONE,
							pos_q - 1'b1, P'(2), line_q, col1);
						nres = nres + 2'd1;
						nx_in_expr   = 1'b1;
						nx_open_kind = tel_pkg::OPEN_NONE;
						nx_prior_bs  = 1'b0;
						done         = 1'b1;
					end else begin
						nx_open_kind = tel_pkg::OPEN_RUN;
						nx_prior_bs  = 1'b0;
					end
				end
				if (!done) begin
					if (nx_open_kind == tel_pkg::OPEN_RUN) begin
						if (b == tel_pkg::CH_PERCENT && !nx_prior_bs)
							nx_held_pct = 1'b1;
						else
							nx_prior_bs = (b == tel_pkg::CH_BACKSLASH);
					end else begin
						nx_open_off = pos_q;
						nx_prior_bs = 1'b0;
						if (b == tel_pkg::CH_PERCENT) begin
							nx_held_pct = 1'b1;
						end else begin
							nx_open_kind = tel_pkg::OPEN_RUN;
							nx_prior_bs  = (b == tel_pkg::CH_BACKSLASH);
						end
					end
				end
			end else if (open_kind_q == tel_pkg::OPEN_STRING) begin
				if (b == tel_pkg::CH_QUOTE) begin
					res[0] = mk(tel_pkg::K_STRING, tel_pkg::E_NONE, open_off_q,
						pos_q + 1'b1 - open_off_q, line_q, col1);
					nres = 2'd1;
					nx_open_kind = tel_pkg::OPEN_NONE;
				end
			end else if (open_kind_q == tel_pkg::OPEN_IDENT) begin
				if (is_letter(b) || (b >= tel_pkg::CH_DIGIT_0 && b <= tel_pkg::CH_DIGIT_9)) begin
					nx_kw = (kw_q == tel_pkg::KW_O && b == tel_pkg::CH_LOWER_R) ?
						tel_pkg::KW_OR : tel_pkg::KW_NONE;
				end else begin
					res[0] = mk((kw_q == tel_pkg::KW_OR) ? tel_pkg::K_OR : tel_pkg::K_IDENT,
						tel_pkg::E_NONE, open_off_q, pos_q - open_off_q, line_q, col_q);
					nres = 2'd1;
					nx_open_kind = tel_pkg::OPEN_NONE;
					nx_kw        = tel_pkg::KW_NONE;
					fresh        = 1'b1;
				end
			end else begin
				fresh = 1'b1;
			end
			if (fresh) begin
				case (b)
					tel_pkg::CH_NEWLINE: begin
						nx_line = line_q + 16'd1;
						nx_col  = 16'd1;
					end
					tel_pkg::CH_SPACE, tel_pkg::CH_CR, tel_pkg::CH_TAB: begin
					end
					tel_pkg::CH_COMMA: begin
						res[nres[0]] = mk(tel_pkg::K_COMMA, tel_pkg::E_NONE, pos_q, P'(1),
							line_q, col1);
						nres = nres + 2'd1;
					end
					tel_pkg::CH_LPAREN: begin
						res[nres[0]] = mk(tel_pkg::K_LPAREN, tel_pkg::E_NONE, pos_q, P'(1),
							line_q, col1);
						nres = nres + 2'd1;
					end
					tel_pkg::CH_RPAREN: begin
						res[nres[0]] = mk(tel_pkg::K_RPAREN, tel_pkg::E_NONE, pos_q, P'(1),
							line_q, col1);
						nres = nres + 2'd1;
					end
					tel_pkg::CH_RBRACE: begin
						res[nres[0]] = mk(tel_pkg::K_SEQ_END, tel_pkg::E_NONE, pos_q, P'(1),
							line_q, col1);
						nres = nres + 2'd1;
						nx_in_expr = 1'b0;
					end
					tel_pkg::CH_QUOTE: begin
						nx_open_kind = tel_pkg::OPEN_STRING;
						nx_open_off  = pos_q;
					end
					default: begin
						if (is_letter(b)) begin
							nx_open_kind = tel_pkg::OPEN_IDENT;
							nx_open_off  = pos_q;
							nx_kw = (b == tel_pkg::CH_LOWER_O) ? tel_pkg::KW_O : tel_pkg::KW_NONE;
						end else begin
							res[nres[0]] = mk(tel_pkg::K_ERROR, tel_pkg::E_UNEXPECTED, pos_q,
								'0, line_q, col1);
							nres = nres + 2'd1;
						end
					end
				endcase
			end
		end
		if (nres == 2'd2)
			res[1].last_of_run = 1'b1;
		else if (nres == 2'd1)
			res[0].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (src_ready) begin
			s1_valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid)
			s1_item_s1 <= src_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_expr_q   <= 1'b0;
			open_kind_q <= tel_pkg::OPEN_NONE;
			open_off_q  <= '0;
			pos_q       <= '0;
			line_q      <= 16'd1;
			col_q       <= 16'd0;
			held_pct_q  <= 1'b0;
			prior_bs_q  <= 1'b0;
			kw_q        <= tel_pkg::KW_NONE;
		end else if (process) begin
			in_expr_q   <= nx_in_expr;
			open_kind_q <= nx_open_kind;
			open_off_q  <= nx_open_off;
			pos_q       <= nx_pos;
			line_q      <= nx_line;
			col_q       <= nx_col;
			held_pct_q  <= nx_held_pct;
			prior_bs_q  <= nx_prior_bs;
			kw_q        <= nx_kw;
		end
	end

	logic [1:0] cnt_p;
	logic [1:0] nres_eff;
	assign cnt_p    = cnt_q - {1'b0, pop};
	assign nres_eff = process ? nres : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_p + nres_eff;
		end
	end

	// shift out the taken item, then append this cycle's tokens behind what remains
	always_ff @(posedge clk) begin
		for (int i = 0; i < tel_pkg::QUEUE_DEPTH; i++) begin
			if (nres_eff != 2'd0 && 2'(i) == cnt_p)
				q_q[i] <= res[0];
			else if (nres_eff == 2'd2 && 2'(i) == cnt_p + 2'd1)
				q_q[i] <= res[1];
			else if (pop && i < tel_pkg::QUEUE_DEPTH - 1)
				q_q[i] <= q_q[(i + 1) % tel_pkg::QUEUE_DEPTH];
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> s1_valid_s1)
		else $error("input stalled with empty input register");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(process && s1_item_s1.end_of_source) |=> (pos_q == '0 && !in_expr_q && line_q == 16'd1))
		else $error("state not returned to reset after end of source");

	a_text_open_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!in_expr_q |-> (open_kind_q == tel_pkg::OPEN_NONE || open_kind_q == tel_pkg::OPEN_RUN))
		else $error("string or identifier open in text mode");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench for the template expression lexer: directed table, random sources, predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		tel_pkg::src_item_t item;
		bit                 typed;
		tel_pkg::tok_item_t token;
	} step_row_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_ready;
	tel_pkg::src_item_t src_item  = '0;
	logic               tok_valid;
	logic               tok_ready = 1'b0;
	tel_pkg::tok_item_t tok_item;

	int src_idle_pct = 0;
	int tok_idle_pct = 0;
	int mismatch_count = 0;

	tel_pkg::tok_item_t expected_tokens[$];
	tel_pkg::src_item_t source_items[$];
	step_row_t          directed_steps[26];

	logic               lx_in_expr;
	logic [1:0]         lx_open_kind;
	logic [1:0]         lx_keyword;
	logic [15:0]        lx_open_off;
	logic [15:0]        lx_pos;
	logic [15:0]        lx_line;
	logic [15:0]        lx_col;
	logic               lx_held_pct;
	logic               lx_after_bslash;
	tel_pkg::tok_item_t step_tokens[2];
	int                 step_count;

	template_expression_lexer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_ident_start(logic [7:0] b);
		return (b >= tel_pkg::CH_LOWER_A && b <= tel_pkg::CH_LOWER_Z)
			|| (b >= tel_pkg::CH_UPPER_A && b <= tel_pkg::CH_UPPER_Z)
			|| b == tel_pkg::CH_UNDERSCORE;
	endfunction

	function automatic bit is_ident_char(logic [7:0] b);
		return is_ident_start(b) || (b >= tel_pkg::CH_DIGIT_0 && b <= tel_pkg::CH_DIGIT_9);
	endfunction

	task automatic clear_lexer();
		lx_in_expr      = 1'b0;
		lx_open_kind    = tel_pkg::OPEN_NONE;
		lx_open_off     = '0;
		lx_pos          = '0;
		lx_line         = 16'd1;
		lx_col          = '0;
		lx_held_pct     = 1'b0;
		lx_after_bslash = 1'b0;
		lx_keyword      = tel_pkg::KW_NONE;
	endtask

	task automatic emit_token(logic [3:0] kind, logic [1:0] err, logic [15:0] off,
			logic [15:0] len, logic [15:0] colv);
		step_tokens[step_count] = '{kind, err, off, len, lx_line, colv, 1'b0};
		step_count++;
	endtask

	task automatic lex_expression_byte(logic [7:0] b, logic [15:0] p);
		case (b)
			tel_pkg::CH_NEWLINE: begin
				lx_line = lx_line + 16'd1;
				lx_col  = 16'd1;
			end
			tel_pkg::CH_SPACE, tel_pkg::CH_CR, tel_pkg::CH_TAB: ;
			tel_pkg::CH_COMMA:
				emit_token(tel_pkg::K_COMMA, tel_pkg::E_NONE, p, 16'd1, lx_col);
			tel_pkg::CH_LPAREN:
				emit_token(tel_pkg::K_LPAREN, tel_pkg::E_NONE, p, 16'd1, lx_col);
			tel_pkg::CH_RPAREN:
				emit_token(tel_pkg::K_RPAREN, tel_pkg::E_NONE, p, 16'd1, lx_col);
			tel_pkg::CH_RBRACE: begin
				emit_token(tel_pkg::K_SEQ_END, tel_pkg::E_NONE, p, 16'd1, lx_col);
				lx_in_expr = 1'b0;
			end
			tel_pkg::CH_QUOTE: begin
				lx_open_kind = tel_pkg::OPEN_STRING;
				lx_open_off  = p;
			end
			default: begin
				if (is_ident_start(b)) begin
					lx_open_kind = tel_pkg::OPEN_IDENT;
					lx_open_off  = p;
					lx_keyword   = (b == tel_pkg::CH_LOWER_O) ? tel_pkg::KW_O : tel_pkg::KW_NONE;
				end else begin
					emit_token(tel_pkg::K_ERROR, tel_pkg::E_UNEXPECTED, p, 16'd0, lx_col);
				end
			end
		endcase
	endtask

	task automatic lex_byte(tel_pkg::src_item_t it);
		logic [7:0]  b;
		logic [15:0] p;
		logic [15:0] c;
		bit          opened;
		b = it.source_byte;
		p = lx_pos;
		c = lx_col;
		opened = 1'b0;
		step_count = 0;
		if (it.end_of_source) begin
			if (!lx_in_expr) begin
				if (lx_held_pct || lx_open_kind == tel_pkg::OPEN_RUN)
					emit_token(tel_pkg::K_TEXT, tel_pkg::E_NONE, lx_open_off,
						p - lx_open_off, c);
			end else if (lx_open_kind == tel_pkg::OPEN_IDENT) begin
				emit_token((lx_keyword == tel_pkg::KW_OR) ? tel_pkg::K_OR : tel_pkg::K_IDENT,
					tel_pkg::E_NONE, lx_open_off, p - lx_open_off, c);
			end else if (lx_open_kind == tel_pkg::OPEN_STRING) begin
				emit_token(tel_pkg::K_ERROR, tel_pkg::E_UNTERM, lx_open_off, 16'd0, c);
			end
			emit_token(tel_pkg::K_END, tel_pkg::E_NONE, p, 16'd0, c);
			clear_lexer();
		end else begin
			lx_pos = p + 16'd1;
			lx_col = c + 16'd1;
			if (!lx_in_expr) begin
				if (lx_held_pct) begin
					lx_held_pct = 1'b0;
					lx_after_bslash = 1'b0;
					if (b == tel_pkg::CH_LBRACE) begin
						if (lx_open_kind == tel_pkg::OPEN_RUN)
							emit_token(tel_pkg::K_TEXT, tel_pkg::E_NONE, lx_open_off,
								p - 16'd1 - lx_open_off, c - 16'd1);
						emit_token(tel_pkg::K_SEQ_START, tel_pkg::E_NONE, p - 16'd1, 16'd2,
							lx_col);
						lx_in_expr   = 1'b1;
						lx_open_kind = tel_pkg::OPEN_NONE;
						opened       = 1'b1;
					end else begin
						lx_open_kind = tel_pkg::OPEN_RUN;
					end
				end
				if (!opened) begin
					if (lx_open_kind == tel_pkg::OPEN_RUN) begin
						if (b == tel_pkg::CH_PERCENT && !lx_after_bslash)
							lx_held_pct = 1'b1;
						else
							lx_after_bslash = (b == tel_pkg::CH_BACKSLASH);
					end else begin
						lx_open_off = p;
						lx_after_bslash = 1'b0;
						if (b == tel_pkg::CH_PERCENT) begin
							lx_held_pct = 1'b1;
						end else begin
							lx_open_kind = tel_pkg::OPEN_RUN;
							lx_after_bslash = (b == tel_pkg::CH_BACKSLASH);
						end
					end
				end
			end else if (lx_open_kind == tel_pkg::OPEN_STRING) begin
				if (b == tel_pkg::CH_QUOTE) begin
					emit_token(tel_pkg::K_STRING, tel_pkg::E_NONE, lx_open_off,
						p + 16'd1 - lx_open_off, lx_col);
					lx_open_kind = tel_pkg::OPEN_NONE;
				end
			end else if (lx_open_kind == tel_pkg::OPEN_IDENT) begin
				if (is_ident_char(b)) begin
					lx_keyword = (lx_keyword == tel_pkg::KW_O && b == tel_pkg::CH_LOWER_R) ?
						tel_pkg::KW_OR : tel_pkg::KW_NONE;
				end else begin
					emit_token((lx_keyword == tel_pkg::KW_OR) ? tel_pkg::K_OR : tel_pkg::K_IDENT,
						tel_pkg::E_NONE, lx_open_off, p - lx_open_off, c);
					lx_open_kind = tel_pkg::OPEN_NONE;
					lx_keyword   = tel_pkg::KW_NONE;
					lex_expression_byte(b, p);
				end
			end else begin
				lx_open_kind = tel_pkg::OPEN_NONE;
				lex_expression_byte(b, p);
			end
		end
		if (step_count > 0)
			step_tokens[step_count - 1].last_of_run = 1'b1;
	endtask

	task automatic send_item(tel_pkg::src_item_t it, bit typed, tel_pkg::tok_item_t typed_tok);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		do @(posedge clk); while (!src_ready);
		lex_byte(it);
		if (typed) begin
			expected_tokens.push_back(typed_tok);
		end else begin
			for (int k = 0; k < step_count; k++)
				expected_tokens.push_back(step_tokens[k]);
		end
	endtask

	task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_token(tel_pkg::tok_item_t got);
		tel_pkg::tok_item_t want;
		if (expected_tokens.size() == 0) begin
			$error("token kind %0d at offset %0d with nothing expected", got.token_kind,
				got.token_offset);
			mismatch_count++;
		end else begin
			want = expected_tokens.pop_front();
			compare_field("token_kind", want.token_kind, got.token_kind);
			compare_field("error_kind", want.error_kind, got.error_kind);
			compare_field("token_offset", want.token_offset, got.token_offset);
			compare_field("token_length", want.token_length, got.token_length);
			compare_field("line_number", want.line_number, got.line_number);
			compare_field("column_number", want.column_number, got.column_number);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && tok_valid && tok_ready)
			check_token(tok_item);
		tok_ready <= ($urandom_range(0, 99) >= tok_idle_pct);
	end

	function automatic logic [7:0] pick_letter();
		case ($urandom_range(0, 3))
			0: return tel_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
			1: return tel_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
			2: return tel_pkg::CH_UNDERSCORE;
			default: return ($urandom_range(0, 1) == 0) ? tel_pkg::CH_LOWER_O : tel_pkg::CH_LOWER_R;
		endcase
	endfunction

	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return pick_letter();
			4: return tel_pkg::CH_BACKSLASH;
			5: return tel_pkg::CH_PERCENT;
			6: return tel_pkg::CH_LBRACE;
			7: return tel_pkg::CH_NEWLINE;
			8: return tel_pkg::CH_SPACE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic append_byte(logic [7:0] b);
		source_items.push_back('{b, 1'b0});
	endtask

	task automatic append_expression_part();
		logic [7:0] b;
		case ($urandom_range(0, 10))
			0: begin
				case ($urandom_range(0, 2))
					0: append_byte(tel_pkg::CH_SPACE);
					1: append_byte(tel_pkg::CH_TAB);
					default: append_byte(tel_pkg::CH_CR);
				endcase
			end
			1: append_byte(tel_pkg::CH_NEWLINE);
			2: append_byte(tel_pkg::CH_COMMA);
			3: append_byte(tel_pkg::CH_LPAREN);
			4: append_byte(tel_pkg::CH_RPAREN);
			5, 6: begin
				append_byte(pick_letter());
				repeat ($urandom_range(0, 4))
					append_byte(($urandom_range(0, 3) == 0) ?
						tel_pkg::CH_DIGIT_0 + 8'($urandom_range(0, 9)) : pick_letter());
			end
			7: begin
				append_byte(tel_pkg::CH_LOWER_O);
				append_byte(tel_pkg::CH_LOWER_R);
			end
			8: begin
				append_byte(tel_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 4)) begin
					b = 8'($urandom_range(0, 255));
					append_byte((b == tel_pkg::CH_QUOTE) ? tel_pkg::CH_SPACE : b);
				end
				if ($urandom_range(0, 7) != 0)
					append_byte(tel_pkg::CH_QUOTE);
			end
			9: append_byte(tel_pkg::CH_LOWER_O);
			default: append_byte(8'($urandom_range(0, 255)));
		endcase
		if ($urandom_range(0, 1) == 0)
			append_byte(tel_pkg::CH_SPACE);
	endtask

	task automatic build_source();
		repeat ($urandom_range(1, 5)) begin
			repeat ($urandom_range(0, 6))
				append_byte(pick_text_byte());
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 7) == 0)
					append_byte(tel_pkg::CH_BACKSLASH);
				append_byte(tel_pkg::CH_PERCENT);
				append_byte(tel_pkg::CH_LBRACE);
				repeat ($urandom_range(0, 8))
					append_expression_part();
				if ($urandom_range(0, 9) != 0)
					append_byte(tel_pkg::CH_RBRACE);
			end
		end
		source_items.push_back('{8'($urandom_range(0, 255)), 1'b1});
	endtask

	initial begin
		int sent;
		directed_steps = '{
			'{'{8'hff, 1'b1}, 1'b1, '{tel_pkg::K_END, tel_pkg::E_NONE, 16'd0, 16'd0, 16'd1,
				16'd0, 1'b1}},
			'{'{tel_pkg::CH_PERCENT, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_LBRACE, 1'b0}, 1'b1,
				'{tel_pkg::K_SEQ_START, tel_pkg::E_NONE, 16'd0, 16'd2, 16'd1, 16'd2, 1'b1}},
			'{'{8'h00, 1'b0}, 1'b1,
				'{tel_pkg::K_ERROR, tel_pkg::E_UNEXPECTED, 16'd2, 16'd0, 16'd1, 16'd3, 1'b1}},
			'{'{8'hff, 1'b0}, 1'b1,
				'{tel_pkg::K_ERROR, tel_pkg::E_UNEXPECTED, 16'd3, 16'd0, 16'd1, 16'd4, 1'b1}},
			'{'{tel_pkg::CH_NEWLINE, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_LOWER_O, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_LOWER_R, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_LPAREN, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_QUOTE, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_NEWLINE, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_QUOTE, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_COMMA, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_UNDERSCORE, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_DIGIT_9, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_RPAREN, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_TAB, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_RBRACE, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_UPPER_Z, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_BACKSLASH, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_PERCENT, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_LBRACE, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_PERCENT, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_LBRACE, 1'b0}, 1'b0, '0},
			'{'{tel_pkg::CH_QUOTE, 1'b0}, 1'b0, '0},
			'{'{8'h00, 1'b1}, 1'b0, '0}
		};
		clear_lexer();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 38;
		tok_idle_pct = 64;
		foreach (directed_steps[i])
			send_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].token);

		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 64 : 0;
			tok_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 38 : 0;
			sent = 0;
			while (sent < 430) begin
				build_source();
				while (source_items.size() != 0) begin
					send_item(source_items.pop_front(), 1'b0, '0);
					sent++;
				end
			end
		end
		src_valid <= 1'b0;

		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
